// ===== rtl/core/cfpa_pkg.sv =====
// Shared constants for the complex fixed-point arithmetic unit.
package cfpa_pkg;

   // Port widths fixed by the interface.
   localparam int unsigned PORT_BITS      = 32;
   localparam int unsigned OPCODE_BITS    = 3;
   localparam int unsigned STATUS_BITS    = 2;

   // Default number format: signed Q16.16.
   localparam int unsigned WORD_BITS_DEF  = 32;
   localparam int unsigned FRAC_BITS_DEF  = 16;

   // Operation codes.
   localparam logic [OPCODE_BITS-1:0] OP_LOAD = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_ADD  = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_SUB  = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_MUL  = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_DIV  = 3'd4;
   localparam logic [OPCODE_BITS-1:0] OP_CMP  = 3'd5;
   localparam logic [OPCODE_BITS-1:0] OP_MOD  = 3'd6;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DIVZ = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_SAT  = 2'd2;

endpackage

// ===== rtl/core/complex_fixed_point_alu.sv =====
// Complex fixed-point arithmetic unit with one shared multiplier, divider and root unit.
//
// The block holds a complex accumulator in signed fixed point (WORD_BITS wide,
// FRAC_BITS fraction bits, 16 to 32 and 0 to WORD_BITS-1) and takes one request
// beat at a time; req_stall stays high from acceptance until the response beat
// has been taken. Every operation first forms its products on a single registered
// multiplier, one product a cycle, then combines them in the combine state.
// Division runs a restoring divider, one quotient bit a cycle, for the real and
// then the imaginary part. Every request then squares the accumulator and takes
// its integer square root one result bit a cycle, and the response is offered in
// the cycle after the last root step.
module complex_fixed_point_alu #(
   parameter int unsigned WORD_BITS = cfpa_pkg::WORD_BITS_DEF,
   parameter int unsigned FRAC_BITS = cfpa_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [cfpa_pkg::OPCODE_BITS-1:0]       req_opcode,
   input  logic signed [cfpa_pkg::PORT_BITS-1:0]  req_operand_real,
   input  logic signed [cfpa_pkg::PORT_BITS-1:0]  req_operand_imag,
   input  logic                                   req_write_back,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cfpa_pkg::PORT_BITS-1:0]  rsp_result_real,
   output logic signed [cfpa_pkg::PORT_BITS-1:0]  rsp_result_imag,
   output logic                                   rsp_equal_flag,
   output logic [cfpa_pkg::PORT_BITS-1:0]         rsp_magnitude,
   output logic [cfpa_pkg::STATUS_BITS-1:0]       rsp_status
);
   import cfpa_pkg::*;

   // The word is held to the port width and the fraction to the word.
   localparam int unsigned W    = (WORD_BITS < 16) ? 16 : ((WORD_BITS > 32) ? 32 : WORD_BITS);
   localparam int unsigned F    = (FRAC_BITS > W - 1) ? W - 1 : FRAC_BITS;
   localparam int unsigned PW   = 2 * W;
   localparam int unsigned PW1  = 2 * W + 1;
   localparam int unsigned DVW  = 2 * W + F;
   localparam int unsigned CW   = $clog2(DVW);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_COMB = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_SQ   = 3'd4;
   localparam logic [2:0] S_SQRT = 3'd5;
   localparam logic [2:0] S_RSP  = 3'd6;

   localparam logic [2:0] IDX_SQ_RE = 3'd6;
   localparam logic [2:0] IDX_SQ_IM = 3'd7;

   // Clamps a magnitude with its sign to the signed word; the top bit flags clamping.
   function automatic logic [W:0] sat_mag(input logic neg, input logic ov,
                                          input logic [W-1:0] m);
      logic [W-1:0] lim;
      logic [W:0]   r;
      begin
         lim = {1'b0, {(W-1){1'b1}}} + W'(neg);
         if (ov || m > lim) begin
            r = {1'b1, neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}};
         end else begin
            r = {1'b0, neg ? W'(-m) : m};
         end
         return r;
      end
   endfunction

   // Clamps a sum one bit wider than the word.
   function automatic logic [W:0] sat_sum(input logic signed [W:0] s);
      logic [W:0] r;
      begin
         if (s[W] != s[W-1]) begin
            r = {1'b1, s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}};
         end else begin
            r = {1'b0, s[W-1:0]};
         end
         return r;
      end
   endfunction

   logic [2:0]               state_ff, state_in;
   logic [2:0]               idx_ff, idx_in;
   logic [OPCODE_BITS-1:0]   op_ff, op_in;
   logic signed [W-1:0]      br_ff, br_in, bi_ff, bi_in;
   logic                     st_ff, st_in;
   logic signed [W-1:0]      acc_r_ff, acc_r_in, acc_i_ff, acc_i_in;
   logic signed [PW-1:0]     p_ff [6];
   logic signed [PW-1:0]     p_in [6];
   logic signed [W-1:0]      rr_ff, rr_in, ri_ff, ri_in;
   logic                     eq_ff, eq_in;
   logic                     sat_ff, sat_in;
   logic                     dz_ff, dz_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;
   logic [PW-1:0]            ny_ff, ny_in, den_ff, den_in;
   logic                     nxn_ff, nxn_in, nyn_ff, nyn_in;
   logic                     part_ff, part_in;
   logic [DVW-1:0]           dv_ff, dv_in;
   logic [PW-1:0]            rem_ff, rem_in;
   logic [W-1:0]             q_ff, q_in;
   logic                     qov_ff, qov_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [PW-1:0]            sv_ff, sv_in, res_ff, res_in, bit_ff, bit_in;

   // Shared multiplier operand selection.
   logic signed [W-1:0]      mul_a, mul_b;
   logic signed [PW-1:0]     prod;
   logic [2:0]               p_wr;

   always_comb begin
      case (idx_ff)
         3'd0:    begin mul_a = acc_r_ff; mul_b = br_ff;    end
         3'd1:    begin mul_a = acc_i_ff; mul_b = bi_ff;    end
         3'd2:    begin mul_a = acc_r_ff; mul_b = bi_ff;    end
         3'd3:    begin mul_a = acc_i_ff; mul_b = br_ff;    end
         3'd4:    begin mul_a = br_ff;    mul_b = br_ff;    end
         3'd5:    begin mul_a = bi_ff;    mul_b = bi_ff;    end
         3'd6:    begin mul_a = acc_r_ff; mul_b = acc_r_ff; end
         default: begin mul_a = acc_i_ff; mul_b = acc_i_ff; end
      endcase
      prod = PW'(mul_a) * PW'(mul_b);
      p_wr = (idx_ff[2:1] == 2'b11) ? {2'b00, idx_ff[0]} : idx_ff;
   end

   // Combination of the products.
   logic signed [PW1-1:0]    mx, my, dx, dy;
   logic [PW1-1:0]           mxa, mya, dxa, dya, mxs, mys;
   logic [W:0]               sr_add, si_add, sr_sub, si_sub, sr_mul, si_mul;

   always_comb begin
      mx  = PW1'(p_ff[0]) - PW1'(p_ff[1]);
      my  = PW1'(p_ff[2]) + PW1'(p_ff[3]);
      dx  = PW1'(p_ff[0]) + PW1'(p_ff[1]);
      dy  = PW1'(p_ff[3]) - PW1'(p_ff[2]);
      mxa = mx[PW1-1] ? PW1'(-mx) : PW1'(mx);
      mya = my[PW1-1] ? PW1'(-my) : PW1'(my);
      dxa = dx[PW1-1] ? PW1'(-dx) : PW1'(dx);
      dya = dy[PW1-1] ? PW1'(-dy) : PW1'(dy);
      mxs = mxa >> F;
      mys = mya >> F;
      sr_add = sat_sum((W+1)'(acc_r_ff) + (W+1)'(br_ff));
      si_add = sat_sum((W+1)'(acc_i_ff) + (W+1)'(bi_ff));
      sr_sub = sat_sum((W+1)'(acc_r_ff) - (W+1)'(br_ff));
      si_sub = sat_sum((W+1)'(acc_i_ff) - (W+1)'(bi_ff));
      sr_mul = sat_mag(mx[PW1-1], |mxs[PW1-1:W], mxs[W-1:0]);
      si_mul = sat_mag(my[PW1-1], |mys[PW1-1:W], mys[W-1:0]);
   end

   // Restoring divider step and root step.
   logic [PW:0]              rem_sh;
   logic                     qb;
   logic [W:0]               dq;
   logic [PW:0]              sq_t;
   logic                     sq_ge;
   logic [W:0]               smod;

   always_comb begin
      rem_sh = {rem_ff, dv_ff[DVW-1]};
      qb     = rem_sh >= {1'b0, den_ff};
      sq_t   = {1'b0, res_ff} + {1'b0, bit_ff};
      sq_ge  = {1'b0, sv_ff} >= sq_t;
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      op_in     = op_ff;
      br_in     = br_ff;
      bi_in     = bi_ff;
      st_in     = st_ff;
      acc_r_in  = acc_r_ff;
      acc_i_in  = acc_i_ff;
      p_in      = p_ff;
      rr_in     = rr_ff;
      ri_in     = ri_ff;
      eq_in     = eq_ff;
      sat_in    = sat_ff;
      dz_in     = dz_ff;
      status_in = status_ff;
      ny_in     = ny_ff;
      nxn_in    = nxn_ff;
      nyn_in    = nyn_ff;
      den_in    = den_ff;
      part_in   = part_ff;
      dv_in     = dv_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      qov_in    = qov_ff;
      cnt_in    = cnt_ff;
      sv_in     = sv_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      dq        = '0;
      smod      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               br_in    = req_operand_real[W-1:0];
               bi_in    = req_operand_imag[W-1:0];
               st_in    = req_write_back;
               eq_in    = (acc_r_ff == req_operand_real[W-1:0]) &&
                          (acc_i_ff == req_operand_imag[W-1:0]);
               sat_in   = 1'b0;
               dz_in    = 1'b0;
               idx_in   = '0;
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            p_in[p_wr] = prod;
            idx_in     = idx_ff + 3'd1;
            if (idx_ff == 3'd5) begin
               state_in = S_COMB;
            end
         end

         S_COMB: begin
            rr_in    = acc_r_ff;
            ri_in    = acc_i_ff;
            idx_in   = IDX_SQ_RE;
            state_in = S_SQ;
            case (op_ff)
               OP_LOAD: begin
                  rr_in = br_ff;
                  ri_in = bi_ff;
               end
               OP_ADD: begin
                  rr_in  = sr_add[W-1:0];
                  ri_in  = si_add[W-1:0];
                  sat_in = sr_add[W] | si_add[W];
               end
               OP_SUB: begin
                  rr_in  = sr_sub[W-1:0];
                  ri_in  = si_sub[W-1:0];
                  sat_in = sr_sub[W] | si_sub[W];
               end
               OP_MUL: begin
                  rr_in  = sr_mul[W-1:0];
                  ri_in  = si_mul[W-1:0];
                  sat_in = sr_mul[W] | si_mul[W];
               end
               OP_DIV: begin
                  den_in = PW'(p_ff[4]) + PW'(p_ff[5]);
                  if (den_in == '0) begin
                     dz_in = 1'b1;
                     st_in = 1'b0;
                  end else begin
                     nxn_in   = dx[PW1-1];
                     ny_in    = dya[PW-1:0];
                     nyn_in   = dy[PW1-1];
                     part_in  = 1'b0;
                     dv_in    = DVW'(dxa[PW-1:0]) << F;
                     rem_in   = '0;
                     q_in     = '0;
                     qov_in   = 1'b0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end
               default: begin
                  st_in = 1'b0;
               end
            endcase
            if (state_in == S_SQ && st_in) begin
               acc_r_in = rr_in;
               acc_i_in = ri_in;
            end
         end

         S_DIV: begin
            rem_in = qb ? PW'(rem_sh - {1'b0, den_ff}) : rem_sh[PW-1:0];
            dv_in  = dv_ff << 1;
            q_in   = {q_ff[W-2:0], qb};
            qov_in = qov_ff | q_ff[W-1];
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DVW - 1)) begin
               dq = sat_mag(part_ff ? nyn_ff : nxn_ff, qov_in, q_in);
               sat_in = sat_ff | dq[W];
               if (!part_ff) begin
                  rr_in   = dq[W-1:0];
                  part_in = 1'b1;
                  dv_in   = DVW'(ny_ff) << F;
                  rem_in  = '0;
                  q_in    = '0;
                  qov_in  = 1'b0;
                  cnt_in  = '0;
               end else begin
                  ri_in    = dq[W-1:0];
                  idx_in   = IDX_SQ_RE;
                  state_in = S_SQ;
                  if (st_ff) begin
                     acc_r_in = rr_ff;
                     acc_i_in = dq[W-1:0];
                  end
               end
            end
         end

         S_SQ: begin
            p_in[p_wr] = prod;
            idx_in     = IDX_SQ_IM;
            if (idx_ff == IDX_SQ_IM) begin
               sv_in    = PW'(p_ff[0]) + PW'(prod);
               res_in   = '0;
               bit_in   = PW'(1) << (PW - 2);
               state_in = S_SQRT;
            end
         end

         S_SQRT: begin
            if (sq_ge) begin
               sv_in  = PW'({1'b0, sv_ff} - sq_t);
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               if (op_ff == OP_MOD) begin
                  smod   = sat_mag(1'b0, 1'b0, res_in[W-1:0]);
                  rr_in  = smod[W-1:0];
                  ri_in  = '0;
                  sat_in = smod[W];
               end
               status_in = dz_ff ? ST_DIVZ : ((sat_in) ? ST_SAT : ST_OK);
               state_in  = S_RSP;
            end
         end

         S_RSP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The state and the accumulator are reset; the other datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         acc_r_ff <= '0;
         acc_i_ff <= '0;
      end else begin
         state_ff <= state_in;
         acc_r_ff <= acc_r_in;
         acc_i_ff <= acc_i_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      br_ff     <= br_in;
      bi_ff     <= bi_in;
      st_ff     <= st_in;
      p_ff      <= p_in;
      rr_ff     <= rr_in;
      ri_ff     <= ri_in;
      eq_ff     <= eq_in;
      sat_ff    <= sat_in;
      dz_ff     <= dz_in;
      status_ff <= status_in;
      ny_ff     <= ny_in;
      nxn_ff    <= nxn_in;
      nyn_ff    <= nyn_in;
      den_ff    <= den_in;
      part_ff   <= part_in;
      dv_ff     <= dv_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      qov_ff    <= qov_in;
      cnt_ff    <= cnt_in;
      sv_ff     <= sv_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
   end

   // Handshake and response beat.
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_RSP);
   assign rsp_result_real = PORT_BITS'(rr_ff);
   assign rsp_result_imag = PORT_BITS'(ri_ff);
   assign rsp_equal_flag  = eq_ff;
   assign rsp_magnitude   = PORT_BITS'(res_ff[W-1:0]);
   assign rsp_status      = status_ff;

`ifndef SYNTHESIS
   // A response is never offered while a request could be taken.
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("response offered while idle");

   // Divide-by-zero status only ever comes from a division.
   a_divz_from_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DIVZ) |-> (op_ff == OP_DIV))
      else $error("divide-by-zero status on another operation");

   // The status code is never the unused value.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_DIVZ ||
                     rsp_status == ST_SAT))
      else $error("unused status code");
`endif

endmodule

// ===== tb/cfpa_checker.sv =====
// Checker for the complex fixed-point arithmetic unit: predicts each result and compares it.
module cfpa_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [cfpa_pkg::OPCODE_BITS-1:0]       req_opcode,
   input  logic signed [cfpa_pkg::PORT_BITS-1:0]  req_operand_real,
   input  logic signed [cfpa_pkg::PORT_BITS-1:0]  req_operand_imag,
   input  logic                                   req_write_back,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [cfpa_pkg::PORT_BITS-1:0]  rsp_result_real,
   input  logic signed [cfpa_pkg::PORT_BITS-1:0]  rsp_result_imag,
   input  logic                                   rsp_equal_flag,
   input  logic [cfpa_pkg::PORT_BITS-1:0]         rsp_magnitude,
   input  logic [cfpa_pkg::STATUS_BITS-1:0]       rsp_status,
   output int                                     mismatches,
   output int                                     outstanding
);
   import cfpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = FRAC_BITS_DEF;

   typedef struct packed {
      logic signed [PORT_BITS-1:0] re;
      logic signed [PORT_BITS-1:0] im;
      logic                        eq;
      logic [PORT_BITS-1:0]        mag;
      logic [STATUS_BITS-1:0]      st;
   } alu_result_type;

   alu_result_type awaited_results[$];
   logic signed [PORT_BITS-1:0] acc_re, acc_im;
   int beats_checked;

   // Saturate a wide value to the signed word range, noting any clipping.
   function automatic logic signed [31:0] clamp(input logic signed [127:0] v, inout bit hit);
      if (v > 128'sd2147483647) begin
         hit = 1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         hit = 1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Integer square root, one result bit for each pair of input bits.
   function automatic logic [63:0] root_of(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] modulus_of(input logic signed [31:0] re,
                                              input logic signed [31:0] im);
      logic signed [127:0] s;
      s = 128'(re) * 128'(re) + 128'(im) * 128'(im);
      return root_of(s[63:0]);
   endfunction

   // Truncating toward zero, apply a sign to a magnitude.
   function automatic logic signed [127:0] signed_mag(input logic signed [127:0] v,
                                                      input logic [127:0] m);
      return (v < 0) ? -$signed(m) : $signed(m);
   endfunction

   // Predict one result and update the accumulator copy.
   function automatic alu_result_type predict_result(input logic [2:0] op,
                                                     input logic signed [31:0] br,
                                                     input logic signed [31:0] bi,
                                                     input logic wb);
      alu_result_type r;
      logic signed [127:0] ar, ai, cr, ci, x, y, den;
      logic [127:0] xm, ym;
      bit hit;
      logic store;
      hit = 0;
      store = wb;
      ar = acc_re;
      ai = acc_im;
      cr = br;
      ci = bi;
      r.re = acc_re;
      r.im = acc_im;
      r.eq = (acc_re == br) && (acc_im == bi);
      r.st = ST_OK;
      case (op)
         OP_LOAD: begin
            r.re = br;
            r.im = bi;
         end
         OP_ADD: begin
            r.re = clamp(ar + cr, hit);
            r.im = clamp(ai + ci, hit);
         end
         OP_SUB: begin
            r.re = clamp(ar - cr, hit);
            r.im = clamp(ai - ci, hit);
         end
         OP_MUL: begin
            x = ar * cr - ai * ci;
            y = ar * ci + ai * cr;
            xm = (x < 0) ? -x : x;
            ym = (y < 0) ? -y : y;
            r.re = clamp(signed_mag(x, xm >> FRAC), hit);
            r.im = clamp(signed_mag(y, ym >> FRAC), hit);
         end
         OP_DIV: begin
            den = cr * cr + ci * ci;
            if (den == 0) begin
               r.st = ST_DIVZ;
               store = 0;
            end else begin
               x = ar * cr + ai * ci;
               y = ai * cr - ar * ci;
               xm = (x < 0) ? -x : x;
               ym = (y < 0) ? -y : y;
               r.re = clamp(signed_mag(x, (xm << FRAC) / den), hit);
               r.im = clamp(signed_mag(y, (ym << FRAC) / den), hit);
            end
         end
         OP_MOD: begin
            r.re = clamp($signed({64'd0, modulus_of(acc_re, acc_im)}), hit);
            r.im = 0;
            store = 0;
         end
         default: store = 0;
      endcase
      if (r.st == ST_OK && hit) r.st = ST_SAT;
      if (store) begin
         acc_re = r.re;
         acc_im = r.im;
      end
      r.mag = PORT_BITS'(modulus_of(acc_re, acc_im));
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: beat %0d %s: got %h, expected %h", $realtime, beats_checked, what,
               got, want);
      mismatches++;
   endtask

   // Compare each response beat, then record the prediction for each request beat.
   always @(posedge clock) begin
      alu_result_type w;
      if (reset) begin
         acc_re = 0;
         acc_im = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: response beat with nothing awaited", $realtime);
               mismatches++;
            end else begin
               w = awaited_results.pop_front();
               if (rsp_result_real !== w.re) report_mismatch("real", rsp_result_real, w.re);
               if (rsp_result_imag !== w.im) report_mismatch("imag", rsp_result_imag, w.im);
               if (rsp_equal_flag !== w.eq)
                  report_mismatch("equal", 32'(rsp_equal_flag), 32'(w.eq));
               if (rsp_magnitude !== w.mag) report_mismatch("magnitude", rsp_magnitude, w.mag);
               if (rsp_status !== w.st)
                  report_mismatch("status", 32'(rsp_status), 32'(w.st));
            end
            beats_checked++;
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(predict_result(req_opcode, req_operand_real,
                                                     req_operand_imag, req_write_back));
      end
      outstanding = awaited_results.size();
   end

   initial begin
      mismatches = 0;
      beats_checked = 0;
   end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench: clock, reset, stimulus, response stalls and the verdict.
module tb;
   import cfpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OPCODE_BITS-1:0] OP_SPARE = 3'd7;
   localparam int RANDOM_BEATS = 1230;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [OPCODE_BITS-1:0] req_opcode = OP_LOAD;
   logic signed [PORT_BITS-1:0] req_operand_real = 0;
   logic signed [PORT_BITS-1:0] req_operand_imag = 0;
   logic req_write_back = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [PORT_BITS-1:0] rsp_result_real, rsp_result_imag;
   logic rsp_equal_flag;
   logic [PORT_BITS-1:0] rsp_magnitude;
   logic [STATUS_BITS-1:0] rsp_status;
   int mismatches, outstanding;
   bit calm = 0;
   int stall_left = 0;
   int op_seen[8];
   int beats_sent = 0;

   always #6 clock = ~clock;

   complex_fixed_point_alu dut (.*);
   cfpa_checker result_check (.*);

   // Response stalls come in random bursts until the calm part of the run.
   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(3) == 0) begin
         stall_left <= $urandom_range(4);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // Offer one request beat, wait for the edge that accepts it and, outside the calm part, sometimes pause.
   task automatic send_beat(input logic [2:0] op, input logic [31:0] re,
                            input logic [31:0] im, input logic wb);
      req_valid <= 1;
      req_opcode <= op;
      req_operand_real <= re;
      req_operand_imag <= im;
      req_write_back <= wb;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      op_seen[op]++;
      beats_sent++;
      if (!calm && $urandom_range(3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
         2: return 0;
         default: return $signed($urandom_range(32'h00100000)) - 32'sh00080000;
      endcase
   endfunction

   // Stimulus: directed corners, then random beats.
   initial begin
      logic [2:0] op;
      logic [31:0] a, b;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_beat(OP_MOD, 0, 0, 1'b1);
      send_beat(OP_LOAD, 32'h7fffffff, 32'h7fffffff, 1'b1);
      send_beat(OP_MOD, 0, 0, 1'b1);
      send_beat(OP_ADD, 32'h00010000, 32'h00000001, 1'b1);
      send_beat(OP_LOAD, 32'h80000000, 32'h80000000, 1'b1);
      send_beat(OP_SUB, 32'h00010000, 32'h00000001, 1'b0);
      send_beat(OP_MUL, 32'h80000000, 32'h80000000, 1'b0);
      send_beat(OP_MOD, 0, 0, 1'b0);
      send_beat(OP_LOAD, 32'h00030000, 32'hfffe8000, 1'b1);
      send_beat(OP_CMP, 32'h00030000, 32'hfffe8000, 1'b1);
      send_beat(OP_CMP, 32'h00030000, 32'hfffe8001, 1'b1);
      send_beat(OP_MUL, 32'h00018000, 32'hffff0000, 1'b1);
      send_beat(OP_DIV, 0, 0, 1'b1);
      send_beat(OP_DIV, 32'h00020000, 32'h00010000, 1'b1);
      send_beat(OP_DIV, 32'h00000001, 32'h00000000, 1'b0);
      send_beat(OP_DIV, 32'h80000000, 32'h80000000, 1'b1);
      send_beat(OP_SPARE, 32'h12345678, 32'h9abcdef0, 1'b1);
      send_beat(OP_ADD, 32'h7fffffff, 32'h80000000, 1'b0);
      send_beat(OP_SUB, 32'hffffffff, 32'h00000001, 1'b1);
      send_beat(OP_LOAD, 0, 0, 1'b0);
      // Hold off until every awaited result has come back.
      req_valid <= 0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == RANDOM_BEATS - 150) calm = 1;
         op = 3'($urandom_range(7));
         if ($urandom_range(5) == 0) op = OP_LOAD;
         a = pick_value();
         b = pick_value();
         send_beat(op, a, b, 1'($urandom_range(1)));
      end
      req_valid <= 0;
      do @(negedge clock); while (outstanding != 0);
      repeat (250) @(posedge clock);
      $display("Covered %0d beats: load %0d, add %0d, sub %0d, mul %0d, div %0d,",
               beats_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
      $display("compare %0d, modulus %0d, spare code %0d; %0d results left over.",
               op_seen[5], op_seen[6], op_seen[7], outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #30ms;
      $display("Timed out with %0d results awaited.", outstanding);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/cfpa_pkg.sv
rtl/core/complex_fixed_point_alu.sv
tb/cfpa_checker.sv
tb/tb.sv
